// File: rtl/afi_pkg.sv
package afi_pkg;

    localparam int DATA_BITS   = 8;
    localparam int INDEX_BITS  = 16;
    localparam int OFS_OUT_BITS = 24;
    localparam int LEN_BITS    = 13;
    localparam int PROF_BITS   = 3;
    localparam int RATE_BITS   = 17;
    localparam int CHAN_BITS   = 3;
    localparam int STAT_BITS   = 2;
    localparam int TDATA_BITS  = 96;
    localparam int HDR_BYTES   = 6;

    localparam logic [7:0]          SYNC_HI  = 8'hFF;
    localparam logic [3:0]          SYNC_LO  = 4'hF;
    localparam logic [LEN_BITS-1:0] MIN_LEN  = 13'd7;

    localparam logic [STAT_BITS-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_BITS-1:0] ST_NO_SYNC  = 2'd1;
    localparam logic [STAT_BITS-1:0] ST_SHORT    = 2'd2;
    localparam logic [STAT_BITS-1:0] ST_OVERFLOW = 2'd3;

    localparam logic KIND_FRAME   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_HEAD,
        PH_SKIP,
        PH_STOP
    } afi_phase_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] chan;
        logic [3:0] rate_idx;
        logic [1:0] prof_m1;
        logic       prot;
        logic       ver;
    } afi_info_t;

    typedef struct packed {
        logic                    kind;
        logic [INDEX_BITS-1:0]   index;
        logic [OFS_OUT_BITS-1:0] offset;
        logic [LEN_BITS-1:0]     length;
        logic                    ver;
        logic                    prot;
        logic [PROF_BITS-1:0]    profile;
        logic [RATE_BITS-1:0]    rate;
        logic [CHAN_BITS-1:0]    chan;
        logic [INDEX_BITS-1:0]   total;
        logic [STAT_BITS-1:0]    status;
    } afi_rec_t;

    typedef struct packed {
        logic [1:0] count;
        afi_rec_t   rec_a;
        afi_rec_t   rec_b;
    } afi_push_t;

    function automatic logic [RATE_BITS-1:0] rate_hz(input logic [3:0] idx);
        logic [RATE_BITS-1:0] hz;
        case (idx)
            4'd0:    hz = 17'd96000;
            4'd1:    hz = 17'd88200;
            4'd2:    hz = 17'd64000;
            4'd3:    hz = 17'd48000;
            4'd4:    hz = 17'd44100;
            4'd5:    hz = 17'd32000;
            4'd6:    hz = 17'd24000;
            4'd7:    hz = 17'd22050;
            4'd8:    hz = 17'd16000;
            4'd9:    hz = 17'd12000;
            4'd10:   hz = 17'd11025;
            4'd11:   hz = 17'd8000;
            4'd12:   hz = 17'd7350;
            default: hz = '0;
        endcase
        return hz;
    endfunction

endpackage

// File: rtl/afi_parser.sv
module afi_parser #(
    parameter int OFFSET_BITS = 24,
    parameter int COUNT_BITS  = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              fire,
    input  logic [afi_pkg::DATA_BITS-1:0]     data_byte,
    input  logic                              is_last,
    input  logic [afi_pkg::OFS_OUT_BITS-1:0]  start_offset,
    output afi_pkg::afi_push_t                push
);
    import afi_pkg::*;

    afi_phase_t             phase_reg, phase_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] cur_reg, cur_next;
    logic [OFFSET_BITS-1:0] nxt_reg, nxt_next;
    logic [COUNT_BITS-1:0]  frames_reg, frames_next;
    logic [2:0]             hidx_reg, hidx_next;
    afi_info_t              info_reg, info_next;
    logic [STAT_BITS-1:0]   err_reg, err_next;
    logic [7:0]             hdr_reg [HDR_BYTES-1];

    logic [OFFSET_BITS-1:0] start_ext;
    logic                   start_hit, head_done, first, sync_ok;
    logic                   sync_bad, len_bad, cnt_full, frame_ok, last_fire;
    logic [LEN_BITS-1:0]    len;
    afi_info_t              info_dec, info_mid;
    logic [STAT_BITS-1:0]   err_mid, sum_status;
    logic [COUNT_BITS-1:0]  frames_mid;
    afi_rec_t               frame_rec, sum_rec;

    assign start_ext = OFFSET_BITS'(start_offset);
    assign start_hit = fire && ((phase_reg == PH_WAIT && pos_reg == start_ext) ||
                                (phase_reg == PH_SKIP && pos_reg == nxt_reg));
    assign head_done = fire && phase_reg == PH_HEAD && hidx_reg == 3'(HDR_BYTES - 1);
    assign first     = frames_reg == '0;
    assign sync_ok   = hdr_reg[0] == SYNC_HI && hdr_reg[1][7:4] == SYNC_LO;
    assign len       = {hdr_reg[3][1:0], hdr_reg[4], data_byte[7:5]};
    assign sync_bad  = head_done && first && !sync_ok;
    assign len_bad   = head_done && !sync_bad && len < MIN_LEN;
    assign cnt_full  = head_done && !sync_bad && !len_bad && (&frames_reg);
    assign frame_ok  = head_done && !sync_bad && !len_bad && !cnt_full;
    assign last_fire = fire && is_last;

    assign info_dec = '{valid: 1'b1,
                        chan: {hdr_reg[2][0], hdr_reg[3][7:6]},
                        rate_idx: hdr_reg[2][5:2],
                        prof_m1: hdr_reg[2][7:6],
                        prot: hdr_reg[1][0],
                        ver: hdr_reg[1][3]};
    assign info_mid   = (head_done && first && !sync_bad) ? info_dec : info_reg;
    assign frames_mid = frame_ok ? frames_reg + 1'b1 : frames_reg;

    always_comb begin
        err_mid = err_reg;
        if (sync_bad) begin
            err_mid = ST_NO_SYNC;
        end else if (len_bad) begin
            err_mid = ST_SHORT;
        end else if (cnt_full) begin
            err_mid = ST_OVERFLOW;
        end
        sum_status = err_mid;
        if (err_mid == ST_OK && frames_mid == '0) begin
            sum_status = ST_NO_SYNC;
        end
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (start_hit) begin
            phase_next = PH_HEAD;
        end else if (head_done) begin
            phase_next = frame_ok ? PH_SKIP : PH_STOP;
        end
        if (last_fire) begin
            phase_next = PH_WAIT;
        end
    end

    // records
    always_comb begin
        frame_rec         = '0;
        frame_rec.kind    = KIND_FRAME;
        frame_rec.index   = INDEX_BITS'(frames_reg);
        frame_rec.offset  = OFS_OUT_BITS'(cur_reg);
        frame_rec.length  = len;
        frame_rec.total   = INDEX_BITS'(frames_mid);
        frame_rec.status  = ST_OK;
        sum_rec           = '0;
        sum_rec.kind      = KIND_SUMMARY;
        sum_rec.total     = INDEX_BITS'(frames_mid);
        sum_rec.status    = sum_status;
        if (info_mid.valid) begin
            frame_rec.ver     = info_mid.ver;
            frame_rec.prot    = info_mid.prot;
            frame_rec.profile = PROF_BITS'(info_mid.prof_m1) + 1'b1;
            frame_rec.rate    = rate_hz(info_mid.rate_idx);
            frame_rec.chan    = info_mid.chan;
            sum_rec.ver       = frame_rec.ver;
            sum_rec.prot      = frame_rec.prot;
            sum_rec.profile   = frame_rec.profile;
            sum_rec.rate      = frame_rec.rate;
            sum_rec.chan      = frame_rec.chan;
        end
        push.rec_a = frame_ok ? frame_rec : sum_rec;
        push.rec_b = sum_rec;
        push.count = {1'b0, frame_ok} + {1'b0, last_fire};
    end

    // datapath state
    always_comb begin
        pos_next    = pos_reg;
        cur_next    = cur_reg;
        nxt_next    = nxt_reg;
        hidx_next   = hidx_reg;
        frames_next = frames_mid;
        info_next   = info_mid;
        err_next    = err_mid;
        if (fire) begin
            pos_next = pos_reg + 1'b1;
        end
        if (start_hit) begin
            cur_next  = pos_reg;
            hidx_next = 3'd1;
        end else if (fire && phase_reg == PH_HEAD) begin
            hidx_next = hidx_reg + 1'b1;
        end
        if (frame_ok) begin
            nxt_next = cur_reg + OFFSET_BITS'(len);
        end
        if (last_fire) begin
            pos_next    = '0;
            cur_next    = '0;
            nxt_next    = '0;
            hidx_next   = '0;
            frames_next = '0;
            info_next   = '0;
            err_next    = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_WAIT;
            pos_reg    <= '0;
            cur_reg    <= '0;
            nxt_reg    <= '0;
            hidx_reg   <= '0;
            frames_reg <= '0;
            info_reg   <= '0;
            err_reg    <= ST_OK;
        end else begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            cur_reg    <= cur_next;
            nxt_reg    <= nxt_next;
            hidx_reg   <= hidx_next;
            frames_reg <= frames_next;
            info_reg   <= info_next;
            err_reg    <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start_hit) begin
            hdr_reg[0] <= data_byte;
        end else if (fire && phase_reg == PH_HEAD && hidx_reg < 3'(HDR_BYTES - 1)) begin
            hdr_reg[hidx_reg] <= data_byte;
        end
    end

    a_stop_no_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_STOP |-> !frame_ok)
        else $error("frame record while stopped");
    a_hidx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_HEAD |-> (hidx_reg != 3'd0 && hidx_reg < 3'(HDR_BYTES)))
        else $error("header index out of range");
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        last_fire |=> (phase_reg == PH_WAIT && frames_reg == '0 && pos_reg == '0))
        else $error("run not cleared after last word");

endmodule

// File: rtl/afi_out_fifo.sv
module afi_out_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  afi_pkg::afi_push_t push,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output afi_pkg::afi_rec_t  out_rec
);
    import afi_pkg::*;

    localparam int DEPTH = 4;

    afi_rec_t   mem_reg [DEPTH];
    logic [1:0] wr_reg, wr_next;
    logic [1:0] rd_reg, rd_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;

    assign room      = cnt_reg <= 3'(DEPTH - 2);
    assign out_valid = cnt_reg != 3'd0;
    assign out_rec   = mem_reg[rd_reg];
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_next  = wr_reg + push.count;
        rd_next  = rd_reg + {1'b0, pop};
        cnt_next = cnt_reg + {1'b0, push.count} - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem_reg[wr_reg] <= push.rec_a;
        end
        if (push.count == 2'd2) begin
            mem_reg[wr_reg + 2'd1] <= push.rec_b;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'(DEPTH))
        else $error("record queue overflow");
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count != 2'd0 |-> room)
        else $error("push without room");
    a_ptr_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 3'(DEPTH)) || (2'(wr_reg - rd_reg) == cnt_reg[1:0]))
        else $error("queue pointers disagree with count");

endmodule

// File: rtl/adts_frame_indexer.sv
// ADTS frame indexer.
// Input stream s_*: one byte of the ADTS stream per word, s_tlast on the
// final byte. Output stream m_*: one record per word; m_tuser is 0 for a
// frame record (offset, length, index) and 1 for the end-of-stream summary
// that closes a run. A byte that completes a header and is also the last
// byte yields two words, the frame record first.
// Config channel cfg_*: start offset in bytes; write it only while idle.
// cfg_ready is always high.
// An accepted byte is held in the input register and parsed once the record
// queue has room; its records are queued at that edge and show on m_* after it.
// Throughput: one byte per cycle while the record queue has room, limited
// by the single parse stage; the four-word record queue keeps s_tready high
// while m_tready is low until it holds more than two words.
// Reset (aresetn low, synchronous) clears the run state, empties the queue
// and sets the start offset to 0. A summary also returns the run state to
// reset, keeping the start offset.
module adts_frame_indexer #(
    parameter int OFFSET_BITS = 24,
    parameter int COUNT_BITS  = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [afi_pkg::OFS_OUT_BITS-1:0]  cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,  // data_byte
    input  logic                              s_tlast,  // is_last
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // frame_index, frame_offset, frame_length, mpeg_version, protection_absent,
    // profile, sample_rate, channel_config, frame_total, status
    output logic [afi_pkg::TDATA_BITS-1:0]    m_tdata,
    output logic [0:0]                        m_tuser   // record_kind
);
    import afi_pkg::*;

    logic [OFS_OUT_BITS-1:0] start_reg;
    logic [7:0]              byte_reg;
    logic                    last_reg;
    logic                    hold_reg;
    logic                    room, fire;
    afi_push_t               push;
    afi_rec_t                rec;

    assign cfg_ready = 1'b1;
    assign fire      = hold_reg && room;
    assign s_tready  = !hold_reg || room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0;
            hold_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                start_reg <= cfg_data;
            end
            if (s_tready) begin
                hold_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    afi_parser #(
        .OFFSET_BITS(OFFSET_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .data_byte   (byte_reg),
        .is_last     (last_reg),
        .start_offset(start_reg),
        .push        (push)
    );

    afi_out_fifo u_out_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .room     (room),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_rec  (rec)
    );

    assign m_tuser = rec.kind;
    assign m_tdata = {rec.status, rec.total, rec.chan, rec.rate, rec.profile,
                      rec.prot, rec.ver, rec.length, rec.offset, rec.index};

endmodule

// File: verif/afi_index_checker.sv
module afi_index_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [afi_pkg::OFS_OUT_BITS-1:0] cfg_data,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [7:0]                       s_tdata,
    input  logic                             s_tlast,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [afi_pkg::TDATA_BITS-1:0]   m_tdata,
    input  logic [0:0]                       m_tuser,
    output int                               mismatches,
    output int                               pending
);
    import afi_pkg::*;

    localparam int PRINT_CAP = 40;
    localparam logic [RATE_BITS-1:0] RATE_HZ [16] = '{
        17'd96000, 17'd88200, 17'd64000, 17'd48000, 17'd44100, 17'd32000,
        17'd24000, 17'd22050, 17'd16000, 17'd12000, 17'd11025, 17'd8000,
        17'd7350, 17'd0, 17'd0, 17'd0
    };

    logic [OFS_OUT_BITS-1:0] start_ofs;
    logic [OFS_OUT_BITS-1:0] pos;
    logic [OFS_OUT_BITS-1:0] cur_start;
    logic [OFS_OUT_BITS-1:0] next_start;
    logic [7:0]              hdr [HDR_BYTES];
    logic [INDEX_BITS-1:0]   nframes;
    afi_phase_t              phase;
    afi_info_t               info;
    logic [STAT_BITS-1:0]    err;
    afi_rec_t                records_due[$];
    afi_rec_t                want_rec;
    int                      fail_count = 0;

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= PRINT_CAP) $display("checker: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch($sformatf("%s: got %0d, want %0d", name, got, want));
    endtask

    task automatic clear_run();
        pos = '0;
        cur_start = '0;
        next_start = '0;
        foreach (hdr[i]) hdr[i] = '0;
        nframes = '0;
        phase = PH_WAIT;
        info = '0;
        err = ST_OK;
    endtask

    function automatic afi_rec_t make_record(input logic kind, input logic [INDEX_BITS-1:0] idx,
                                             input logic [OFS_OUT_BITS-1:0] ofs,
                                             input logic [LEN_BITS-1:0] len,
                                             input logic [STAT_BITS-1:0] st);
        afi_rec_t r;
        r = '0;
        r.kind = kind;
        r.index = idx;
        r.offset = ofs;
        r.length = len;
        if (info.valid) begin
            r.ver = info.ver;
            r.prot = info.prot;
            r.profile = {1'b0, info.prof_m1} + 3'd1;
            r.rate = RATE_HZ[info.rate_idx];
            r.chan = info.chan;
        end
        r.total = nframes;
        r.status = st;
        return r;
    endfunction

    task automatic close_header();
        logic [LEN_BITS-1:0] len;
        logic                sync_bad;
        sync_bad = 1'b0;
        if (nframes == '0) begin
            if ({hdr[0], hdr[1][7:4]} != {SYNC_HI, SYNC_LO}) begin
                sync_bad = 1'b1;
            end else begin
                info.ver = hdr[1][3];
                info.prot = hdr[1][0];
                info.prof_m1 = hdr[2][7:6];
                info.rate_idx = hdr[2][5:2];
                info.chan = {hdr[2][0], hdr[3][7:6]};
                info.valid = 1'b1;
            end
        end
        len = {hdr[3][1:0], hdr[4], hdr[5][7:5]};
        if (sync_bad) begin
            err = ST_NO_SYNC;
            phase = PH_STOP;
        end else if (len < MIN_LEN) begin
            err = ST_SHORT;
            phase = PH_STOP;
        end else if (nframes == '1) begin
            err = ST_OVERFLOW;
            phase = PH_STOP;
        end else begin
            nframes = nframes + 1'b1;
            records_due.push_back(make_record(KIND_FRAME, nframes - 1'b1, cur_start, len, ST_OK));
            next_start = cur_start + len;
            phase = PH_SKIP;
        end
    endtask

    task automatic index_byte(input logic [7:0] b, input logic last);
        logic [OFS_OUT_BITS-1:0] k;
        logic [STAT_BITS-1:0]    st;
        if ((phase == PH_WAIT && pos == start_ofs) || (phase == PH_SKIP && pos == next_start)) begin
            cur_start = pos;
            hdr[0] = b;
            phase = PH_HEAD;
        end else if (phase == PH_HEAD) begin
            k = pos - cur_start;
            if (k < HDR_BYTES) hdr[k] = b;
            if (k >= HDR_BYTES - 1) close_header();
        end
        pos = pos + 1'b1;
        if (last) begin
            st = err;
            if (st == ST_OK && nframes == '0) st = ST_NO_SYNC;
            records_due.push_back(make_record(KIND_SUMMARY, '0, '0, '0, st));
            clear_run();
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            start_ofs = '0;
            clear_run();
            records_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (records_due.size() == 0) begin
                    report_mismatch($sformatf("word with no record due, kind %0d index %0d",
                                              m_tuser, m_tdata[15:0]));
                end else begin
                    want_rec = records_due.pop_front();
                    check_field("record_kind", m_tuser, want_rec.kind);
                    check_field("frame_index", m_tdata[15:0], want_rec.index);
                    check_field("frame_offset", m_tdata[39:16], want_rec.offset);
                    check_field("frame_length", m_tdata[52:40], want_rec.length);
                    check_field("mpeg_version", m_tdata[53], want_rec.ver);
                    check_field("protection_absent", m_tdata[54], want_rec.prot);
                    check_field("profile", m_tdata[57:55], want_rec.profile);
                    check_field("sample_rate", m_tdata[74:58], want_rec.rate);
                    check_field("channel_config", m_tdata[77:75], want_rec.chan);
                    check_field("frame_total", m_tdata[93:78], want_rec.total);
                    check_field("status", m_tdata[95:94], want_rec.status);
                end
            end
            if (cfg_valid && cfg_ready) start_ofs = cfg_data;
            if (s_tvalid && s_tready) index_byte(s_tdata, s_tlast);
        end
        pending <= records_due.size();
        mismatches <= fail_count;
    end

endmodule

// File: verif/tb.sv
module tb;
    import afi_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE = 8;
    localparam int RX_HOLD = 200;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [OFS_OUT_BITS-1:0]   cfg_data = '0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [7:0]                s_tdata = '0;
    logic                      s_tlast = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [TDATA_BITS-1:0]     m_tdata;
    logic [0:0]                m_tuser;
    int                        mismatches;
    int                        pending;

    logic [7:0]                stream_q[$];
    logic [OFS_OUT_BITS-1:0]   cur_ofs = '0;
    int                        burst_left = 0;
    bit                        tx_steady = 1'b0;
    bit                        rx_steady = 1'b0;
    bit                        hold_req = 1'b0;

    adts_frame_indexer uut (.*);
    afi_index_checker checker_i (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("tb: errors");
        $finish;
    end

    initial begin : receiver
        int mode;
        int left;
        int tick;
        mode = 0;
        left = 0;
        tick = 0;
        forever begin
            @(posedge aclk);
            tick++;
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (RX_HOLD) @(posedge aclk);
            end
            if (rx_steady) begin
                m_tready <= 1'b1;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(16, 160);
                end
                left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 4) == 0);
                    default: m_tready <= (tick % 5 != 0);
                endcase
            end
        end
    end

    task automatic put_byte(input logic [7:0] b, input logic last);
        int gap;
        if (!tx_steady && burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        if (burst_left > 0) burst_left--;
    endtask

    task automatic send_stream(input logic close);
        foreach (stream_q[i]) put_byte(stream_q[i], close && (i == stream_q.size() - 1));
        stream_q.delete();
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_offset(input logic [OFS_OUT_BITS-1:0] ofs);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= ofs;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_ofs = ofs;
    endtask

    task automatic push_noise(input int n);
        repeat (n) stream_q.push_back(8'($urandom));
    endtask

    function automatic afi_info_t any_fields();
        return afi_info_t'(12'($urandom));
    endfunction

    task automatic push_header(input logic sync_ok, input afi_info_t f,
                               input logic [LEN_BITS-1:0] len);
        logic [7:0] b0;
        logic [7:0] b1;
        b0 = SYNC_HI;
        b1 = {SYNC_LO, f.ver, 2'($urandom_range(0, 3)), f.prot};
        if (!sync_ok) begin
            if ($urandom_range(0, 1) == 1) b0 = 8'($urandom_range(0, 254));
            else b1[7:4] = 4'($urandom_range(0, 14));
        end
        stream_q.push_back(b0);
        stream_q.push_back(b1);
        stream_q.push_back({f.prof_m1, f.rate_idx, 1'($urandom_range(0, 1)), f.chan[2]});
        stream_q.push_back({f.chan[1:0], 4'($urandom_range(0, 15)), len[12:11]});
        stream_q.push_back(len[10:3]);
        stream_q.push_back({len[2:0], 5'($urandom_range(0, 31))});
    endtask

    task automatic build_random_stream();
        int shape;
        int nf;
        int len;
        if (cur_ofs <= 48) push_noise(int'(cur_ofs));
        shape = $urandom_range(0, 19);
        if (shape == 0) begin
            push_noise($urandom_range(1, 12));
        end else if (shape == 1) begin
            push_header(1'b0, any_fields(), 13'($urandom_range(7, 40)));
            push_noise($urandom_range(1, 8));
        end else if (shape == 2) begin
            push_header(1'b1, any_fields(), 13'($urandom_range(7, 40)));
            repeat ($urandom_range(1, 5)) void'(stream_q.pop_back());
        end else begin
            nf = $urandom_range(1, 6);
            for (int f = 0; f < nf; f++) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 300)
                                                  : $urandom_range(7, 24);
                if ($urandom_range(0, 29) == 0) len = $urandom_range(0, 6);
                push_header(f == 0 || $urandom_range(0, 3) != 0, any_fields(), 13'(len));
                push_noise(len > 6 ? len - 6 : 0);
            end
            case ($urandom_range(0, 4))
                1: repeat ($urandom_range(1, 8)) if (stream_q.size() > 1) void'(stream_q.pop_back());
                2: begin
                    push_header(1'($urandom_range(0, 1)), any_fields(),
                                13'($urandom_range(7, 60)));
                    repeat ($urandom_range(1, 5)) void'(stream_q.pop_back());
                end
                3: push_header(1'($urandom_range(0, 1)), any_fields(),
                               ($urandom_range(0, 1) == 1) ? 13'h1FFF
                                                           : 13'($urandom_range(7, 8191)));
                4: push_noise($urandom_range(1, 4));
                default: ;
            endcase
        end
    endtask

    initial begin : stimulus
        logic [OFS_OUT_BITS-1:0] ofs;
        int                      phase_bytes;
        afi_info_t               fields;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        write_offset('0);

        stream_q.push_back(SYNC_HI);
        send_stream(1'b1);
        push_header(1'b0, any_fields(), 13'd7);
        push_noise(1);
        send_stream(1'b1);
        push_header(1'b1, '1, '1);
        send_stream(1'b1);
        push_header(1'b1, '0, 13'd7);
        push_noise(1);
        push_header(1'b0, any_fields(), 13'd7);
        push_noise(1);
        push_header(1'b1, any_fields(), 13'd3);
        push_noise(1);
        send_stream(1'b1);
        push_header(1'b1, any_fields(), 13'd0);
        send_stream(1'b1);

        write_offset(24'd3);
        fields = '0;
        fields.rate_idx = 4'd12;
        fields.chan = 3'd5;
        push_noise(3);
        push_header(1'b1, fields, 13'd7);
        push_noise(1);
        send_stream(1'b1);
        write_offset('1);
        push_noise(3);
        send_stream(1'b1);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: ofs = '0;
                1: ofs = 24'($urandom_range(1, 48));
                2: ofs = '1;
                3: ofs = 24'($urandom_range(49, 24'hFFFFFF));
                4: ofs = 24'($urandom_range(1, 8));
                default: ofs = '0;
            endcase
            write_offset(ofs);
            phase_bytes = 0;
            if (ofs > 48) begin
                build_random_stream();
                send_stream(1'b1);
            end else begin
                while (phase_bytes < 120) begin
                    build_random_stream();
                    phase_bytes += stream_q.size();
                    send_stream(1'b1);
                end
            end
        end

        // stall the receiver while short frames keep coming
        hold_req = 1'b1;
        repeat (30) begin
            push_header(1'b1, any_fields(), 13'd7);
            push_noise(1);
        end
        send_stream(1'b1);
        wait_idle();

        // stream back to back with both sides steady
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        repeat (20) begin
            push_header(1'b1, any_fields(), 13'd7);
            push_noise(1);
        end
        send_stream(1'b1);
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        wait_idle();
        if (mismatches == 0) $display("tb: clean");
        else $display("tb: errors");
        $finish;
    end

endmodule

// File: files.f
rtl/afi_pkg.sv
rtl/afi_parser.sv
rtl/afi_out_fifo.sv
rtl/adts_frame_indexer.sv
verif/afi_index_checker.sv
verif/tb.sv
